FILE: src/daes_pkg.sv
package daes_pkg;

    localparam int unsigned BlockW = 128;
    localparam int unsigned Rounds = 10;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegKeyOneLow  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegKeyOneHigh = 2'd1;
    localparam logic [CfgIdxW-1:0] RegKeyTwoLow  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegKeyTwoHigh = 2'd3;

    typedef logic [BlockW-1:0] t_block;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sb(input logic [7:0] a);
        sb = SBOX[a];
    endfunction

    // byte i of the state sits at bits 8*i+7:8*i
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = sb(s[8*(r+4*((c+r)%4)) +: 8]);
            end
        end
        sub_shift = t;
    endfunction

    function automatic t_block mix_cols(input t_block t);
        t_block s;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            s[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_cols = s;
    endfunction

    function automatic t_block next_key(input t_block k, input logic [7:0] rcon);
        t_block n;
        logic [31:0] t;
        t = {sb(k[103:96]), sb(k[127:120]), sb(k[119:112]), sb(k[111:104]) ^ rcon};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        next_key = n;
    endfunction

endpackage

FILE: src/daes_round.sv
module daes_round
    import daes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic       i_last,
    input  logic [7:0] i_rcon,
    input  t_block     i_state,
    input  t_block     i_key,
    output t_block     o_state,
    output t_block     o_key
);

    t_block n_key, n_state, w_ss;

    always_comb begin
        w_ss    = sub_shift(i_state);
        n_key   = next_key(i_key, i_rcon);
        n_state = (i_last ? w_ss : mix_cols(w_ss)) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state <= n_state;
            o_key   <= n_key;
        end
    end

endmodule

FILE: src/daes_core.sv
module daes_core
    import daes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_block i_block,
    input  t_block i_key,
    output t_block o_cipher
);

    localparam logic [7:0] RCON [Rounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    t_block r_state [Rounds+1];
    t_block r_key   [Rounds+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state[0] <= i_block ^ i_key;
            r_key[0]   <= i_key;
        end
    end

    for (genvar g = 0; g < Rounds; g++) begin : g_rnd
        daes_round u_round (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_last  (g == Rounds - 1),
            .i_rcon  (RCON[g]),
            .i_state (r_state[g]),
            .i_key   (r_key[g]),
            .o_state (r_state[g+1]),
            .o_key   (r_key[g+1])
        );
    end

    assign o_cipher = r_state[Rounds];

endmodule

FILE: src/dual_aes128_prf.sv
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | block_low[63:0], block_high[127:64]
// m_axis  | out | prf_low[63:0], prf_high[127:64]
// cfg     | in  | idx 0..3: key_one_low/high, key_two_low/high
// Input xor stage, ten round stages and output xor stage;
// one transfer per cycle unless stalled, set by one round per stage.
// Round keys are expanded in-line and travel with each item.
// Synchronous active-low reset clears valid bits and restores reset keys.
// Stall freezes the whole pipeline; s_axis_tready is high whenever the
// output stage is empty or being drained.
module dual_aes128_prf
    import daes_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // block_low, block_high
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // prf_low, prf_high
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);

    localparam int unsigned Depth = Rounds + 2;

    logic [63:0] r_k1_lo, r_k1_hi, r_k2_lo, r_k2_hi;
    logic [Depth-1:0] r_vld;
    logic   w_en;
    t_block w_c1, w_c2, r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1_lo <= 64'd1;
            r_k1_hi <= 64'd0;
            r_k2_lo <= 64'd2;
            r_k2_hi <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegKeyOneLow:  r_k1_lo <= i_cfg_data;
                RegKeyOneHigh: r_k1_hi <= i_cfg_data;
                RegKeyTwoLow:  r_k2_lo <= i_cfg_data;
                RegKeyTwoHigh: r_k2_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    daes_core u_core1 (
        .i_clk (i_clk), .i_en (w_en), .i_block (s_axis_tdata),
        .i_key ({r_k1_hi, r_k1_lo}), .o_cipher (w_c1)
    );

    daes_core u_core2 (
        .i_clk (i_clk), .i_en (w_en), .i_block (s_axis_tdata),
        .i_key ({r_k2_hi, r_k2_lo}), .o_cipher (w_c2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_c1 ^ w_c2;
        end
    end

    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tdata  = r_out;

endmodule

FILE: src/daes_checker.sv
module daes_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind dual_aes128_prf daes_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
